@@ rtl/core/bpa_pkg.sv @@
// Shared constants and types of the buddy page allocator.
// No dependencies.
`default_nettype none
package bpa_pkg;
    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int ORD_W     = 4;
    localparam int TOP_ORDER = 10;
    localparam int CFG_W     = 13;
    localparam int NUM_LISTS = TOP_ORDER + 1;
    localparam int LIST_W    = $clog2(NUM_LISTS);

    localparam logic [ORD_W-1:0] TAG_ALLOCATED = 4'hF;
    localparam logic             OP_ALLOC      = 1'b0;
    localparam logic             OP_FREE       = 1'b1;

    typedef struct packed {
        logic              vld;
        logic [PAGE_W-1:0] pg;
    } link_t;
endpackage
`default_nettype wire

@@ rtl/core/buddy_page_allocator.sv @@
// Buddy page allocator top level: sequencer over the tag and link RAMs.
// Depends on bpa_pkg and bpa_ram.
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_op, s_order, s_page
// m_       out  m_valid/m_ready    m_ok, m_block_page, m_final_order
// cfg_     in   cfg_valid/cfg_ready cfg_data (total_pages)
//
// After reset the tag RAM is swept to allocated, with s_ready low. Allocate: ST_APOP,
// ST_ASPLIT per split; out of memory or bad order: ST_OUT. Free: ST_FCHK, ST_FTAG,
// ST_FPUSH (no ST_FTAG at top order or buddy out of range); each merge adds ST_FTAG,
// ST_FMERGE, ST_FCHK, unlink: ST_UHEAD at list head, else ST_UWALK per entry, ST_USPLICE.
// One transaction in flight; a finished result waits in the output register
// while the next transaction is taken; m_ready low holds the next result back.
// cfg_ready is high only in the tag sweep or when idle with s_valid low.
`default_nettype none
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [ORD_W-1:0]  s_order,
    input  wire logic [PAGE_W-1:0] s_page,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_ok,
    output logic      [PAGE_W-1:0] m_block_page,
    output logic      [ORD_W-1:0]  m_final_order,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_APOP    = 4'd2;
    localparam logic [3:0] ST_ASPLIT  = 4'd3;
    localparam logic [3:0] ST_FCHK    = 4'd4;
    localparam logic [3:0] ST_FTAG    = 4'd5;
    localparam logic [3:0] ST_UHEAD   = 4'd6;
    localparam logic [3:0] ST_UWALK   = 4'd7;
    localparam logic [3:0] ST_USPLICE = 4'd8;
    localparam logic [3:0] ST_FMERGE  = 4'd9;
    localparam logic [3:0] ST_FPUSH   = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [PAGE_W:0]   clr_reg, clr_next;
    logic [CFG_W-1:0]  tp_reg, tp_next;
    logic [PAGE_W-1:0] head_reg [NUM_LISTS];
    logic [PAGE_W-1:0] head_next [NUM_LISTS];
    logic [NUM_LISTS-1:0] hv_reg, hv_next;
    logic [ORD_W-1:0]  ord_reg, ord_next, cur_reg, cur_next;
    logic [PAGE_W-1:0] blk_reg, blk_next, bud_reg, bud_next, prev_reg, prev_next;
    logic [PAGE_W-1:0] walk_reg, walk_next;
    logic              res_ok_reg, res_ok_next;
    logic [PAGE_W-1:0] res_pg_reg, res_pg_next;
    logic [ORD_W-1:0]  res_ord_reg, res_ord_next;
    logic              m_valid_reg, m_valid_next, m_ok_reg, m_ok_next;
    logic [PAGE_W-1:0] m_pg_reg, m_pg_next;
    logic [ORD_W-1:0]  m_ord_reg, m_ord_next;

    logic              tag_we, tag_re, link_we, link_re;
    logic [PAGE_W-1:0] tag_waddr, tag_raddr, link_waddr, link_raddr;
    logic [ORD_W-1:0]  tag_wdata, tag_rdata;
    link_t             link_wdata, link_rdata;

    logic              found_ok;
    logic [ORD_W-1:0]  found;
    logic [LIST_W-1:0] cur_idx, nxt_idx;
    logic [ORD_W-1:0]  nxt_ord;
    logic [PAGE_W:0]   half, limit;
    logic [PAGE_W-1:0] bud_c;

    bpa_ram #(.WIDTH(ORD_W), .DEPTH(NUM_PAGES)) u_tag_ram (
        .aclk(aclk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
        .re(tag_re), .raddr(tag_raddr), .rdata(tag_rdata)
    );

    bpa_ram #(.WIDTH($bits(link_t)), .DEPTH(NUM_PAGES)) u_link_ram (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
    );

    always_comb begin
        found_ok = 1'b0;
        found    = '0;
        for (int i = TOP_ORDER; i >= 0; i--) begin
            if (hv_reg[i] && (ORD_W'(i) >= s_order)) begin
                found_ok = 1'b1;
                found    = ORD_W'(i);
            end
        end
    end

    assign cur_idx = LIST_W'(cur_reg);
    assign nxt_ord = cur_reg - 1'b1;
    assign nxt_idx = LIST_W'(nxt_ord);
    assign half    = {1'b0, blk_reg} + ((PAGE_W+1)'(1) << nxt_ord);
    assign bud_c   = blk_reg ^ (PAGE_W'(1) << cur_reg);
    assign limit   = (tp_reg < CFG_W'(NUM_PAGES)) ? tp_reg : CFG_W'(NUM_PAGES);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        tp_next      = tp_reg;
        head_next    = head_reg;
        hv_next      = hv_reg;
        ord_next     = ord_reg;
        cur_next     = cur_reg;
        blk_next     = blk_reg;
        bud_next     = bud_reg;
        prev_next    = prev_reg;
        walk_next    = walk_reg;
        res_ok_next  = res_ok_reg;
        res_pg_next  = res_pg_reg;
        res_ord_next = res_ord_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_pg_next    = m_pg_reg;
        m_ord_next   = m_ord_reg;
        tag_we = 1'b0; tag_waddr = '0; tag_wdata = TAG_ALLOCATED;
        tag_re = 1'b0; tag_raddr = '0;
        link_we = 1'b0; link_waddr = '0; link_wdata = '0;
        link_re = 1'b0; link_raddr = '0;
        s_ready = 1'b0;

        if (cfg_valid && cfg_ready) begin
            tp_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg[PAGE_W-1:0];
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (PAGE_W+1)'(NUM_PAGES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ord_next    = s_order;
                    res_ok_next = 1'b0;
                    res_pg_next = '0;
                    res_ord_next = '0;
                    if (s_order > ORD_W'(TOP_ORDER)) begin
                        state_next = ST_OUT;
                    end else if (s_op == OP_FREE) begin
                        blk_next   = s_page;
                        cur_next   = s_order;
                        state_next = ST_FCHK;
                    end else if (!found_ok) begin
                        state_next = ST_OUT;
                    end else begin
                        blk_next   = head_reg[LIST_W'(found)];
                        cur_next   = found;
                        link_re    = 1'b1;
                        link_raddr = head_reg[LIST_W'(found)];
                        state_next = ST_APOP;
                    end
                end
            end
            ST_APOP: begin
                head_next[cur_idx] = link_rdata.pg;
                hv_next[cur_idx]   = link_rdata.vld;
                tag_we    = 1'b1;
                tag_waddr = blk_reg;
                state_next = ST_ASPLIT;
            end
            ST_ASPLIT: begin
                if (cur_reg > ord_reg) begin
                    cur_next = nxt_ord;
                    if (half < (PAGE_W+1)'(NUM_PAGES)) begin
                        link_we    = 1'b1;
                        link_waddr = half[PAGE_W-1:0];
                        link_wdata = '{vld: hv_reg[nxt_idx], pg: head_reg[nxt_idx]};
                        head_next[nxt_idx] = half[PAGE_W-1:0];
                        hv_next[nxt_idx]   = 1'b1;
                        tag_we    = 1'b1;
                        tag_waddr = half[PAGE_W-1:0];
                        tag_wdata = nxt_ord;
                    end
                end else begin
                    res_ok_next  = 1'b1;
                    res_pg_next  = blk_reg;
                    res_ord_next = ord_reg;
                    state_next   = ST_OUT;
                end
            end
            ST_FCHK: begin
                bud_next = bud_c;
                if ((cur_reg < ORD_W'(TOP_ORDER)) && ({1'b0, bud_c} < limit)) begin
                    tag_re     = 1'b1;
                    tag_raddr  = bud_c;
                    state_next = ST_FTAG;
                end else begin
                    state_next = ST_FPUSH;
                end
            end
            ST_FTAG: begin
                if (tag_rdata != cur_reg) begin
                    state_next = ST_FPUSH;
                end else if (!hv_reg[cur_idx]) begin
                    state_next = ST_FMERGE;
                end else if (head_reg[cur_idx] == bud_reg) begin
                    link_re    = 1'b1;
                    link_raddr = bud_reg;
                    state_next = ST_UHEAD;
                end else begin
                    prev_next  = head_reg[cur_idx];
                    walk_next  = '0;
                    link_re    = 1'b1;
                    link_raddr = head_reg[cur_idx];
                    state_next = ST_UWALK;
                end
            end
            ST_UHEAD: begin
                head_next[cur_idx] = link_rdata.pg;
                hv_next[cur_idx]   = link_rdata.vld;
                state_next = ST_FMERGE;
            end
            ST_UWALK: begin
                if (!link_rdata.vld) begin
                    state_next = ST_FMERGE;
                end else if (link_rdata.pg == bud_reg) begin
                    link_re    = 1'b1;
                    link_raddr = bud_reg;
                    state_next = ST_USPLICE;
                end else if (walk_reg == PAGE_W'(NUM_PAGES - 1)) begin
                    state_next = ST_FMERGE;
                end else begin
                    prev_next  = link_rdata.pg;
                    walk_next  = walk_reg + 1'b1;
                    link_re    = 1'b1;
                    link_raddr = link_rdata.pg;
                end
            end
            ST_USPLICE: begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata;
                state_next = ST_FMERGE;
            end
            ST_FMERGE: begin
                tag_we    = 1'b1;
                tag_waddr = bud_reg;
                if (bud_reg < blk_reg) begin
                    blk_next = bud_reg;
                end
                cur_next   = cur_reg + 1'b1;
                state_next = ST_FCHK;
            end
            ST_FPUSH: begin
                link_we    = 1'b1;
                link_waddr = blk_reg;
                link_wdata = '{vld: hv_reg[cur_idx], pg: head_reg[cur_idx]};
                head_next[cur_idx] = blk_reg;
                hv_next[cur_idx]   = 1'b1;
                tag_we    = 1'b1;
                tag_waddr = blk_reg;
                tag_wdata = cur_reg;
                res_ok_next  = 1'b1;
                res_pg_next  = blk_reg;
                res_ord_next = cur_reg;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_pg_next    = res_pg_reg;
                    m_ord_next   = res_ord_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            tp_reg      <= CFG_W'(4096);
            hv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            tp_reg      <= tp_next;
            hv_reg      <= hv_next;
            m_valid_reg <= m_valid_next;
        end
        head_reg    <= head_next;
        ord_reg     <= ord_next;
        cur_reg     <= cur_next;
        blk_reg     <= blk_next;
        bud_reg     <= bud_next;
        prev_reg    <= prev_next;
        walk_reg    <= walk_next;
        res_ok_reg  <= res_ok_next;
        res_pg_reg  <= res_pg_next;
        res_ord_reg <= res_ord_next;
        m_ok_reg    <= m_ok_next;
        m_pg_reg    <= m_pg_next;
        m_ord_reg   <= m_ord_next;
    end

    assign cfg_ready     = (state_reg == ST_CLEAR) || ((state_reg == ST_IDLE) && !s_valid);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_block_page  = m_pg_reg;
    assign m_final_order = m_ord_reg;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_block_page == '0 && m_final_order == '0))
        else $error("failed transaction carries nonzero payload");
    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ok) |-> (m_final_order <= ORD_W'(TOP_ORDER)))
        else $error("result order above top order");
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input taken during tag clear");
    a_one_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while one is in flight");
`endif
endmodule
`default_nettype wire

@@ rtl/core/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
